// ===== sv/filtered_hash_join_top_assert.svh =====
// ----------------------------------------------------------------------------
// filtered hash join assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef FILTERED_HASH_JOIN_TOP_ASSERT_SVH
`define FILTERED_HASH_JOIN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FHJ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FHJ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FHJ_ASSERT_NOW(lbl, ante, cons, msg)
`define FHJ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/fhj_pkg.sv =====
// ----------------------------------------------------------------------------
// fhj_pkg
// shared constants and key helpers of the filtered hash join
// ----------------------------------------------------------------------------
package fhj_pkg;

  // table size, a power of two so the slot index wraps by itself
  localparam int unsigned ENTRIES = 16384;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = IDX_W + 1;

  localparam int unsigned IN_W  = 296;
  localparam int unsigned OUT_W = 184;
  localparam int unsigned PAY_W = 152;
  localparam int unsigned KEY_W = 80;

  // hash mixing constants
  localparam logic [63:0] HASH_C1 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_C2 = 64'hBF58476D1CE4E5B9;

  // key is a string: clear every byte after the first zero byte
  function automatic logic [KEY_W-1:0] key_norm(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic             alive;
    res   = '0;
    alive = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (raw[8*i +: 8] == 8'd0) alive = 1'b0;
      if (alive) res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction

endpackage

// ===== sv/filtered_hash_join_top.sv =====
// sequence: accept, hash states H0 to H6, a check state per slot visited, then
// a write or an output state, which waits while the result is not yet taken;
// a probe miss returns to idle from the check state, a filtered build is dropped in idle
// throughput: one item at a time, bound by the linear walk over the key memory
// reset: rst clears control state, then a clearing pass writes every key
// memory entry invalid while s_tready stays low
// ----------------------------------------------------------------------------
// filtered_hash_join_top
// hash join build and probe over an open-addressed key and payload memory
// ----------------------------------------------------------------------------
`include "filtered_hash_join_top_assert.svh"

module filtered_hash_join_top (
  input  logic                      clk,
  input  logic                      rst,
  // config
  input  logic                      cfg_we,
  input  logic [31:0]               cfg_wdata,
  // input beats
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // key_low, key_high, row_app_id, customer_low, customer_high,
  // region_low, region_high, trip_score
  input  logic [fhj_pkg::IN_W-1:0]  s_tdata,
  // req_type
  input  logic                      s_tuser,
  // result beats
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_customer_low, out_customer_high, out_trip_score, out_region_low,
  // out_region_high
  output logic [fhj_pkg::OUT_W-1:0] m_tdata,
  // status
  output logic                      m_tuser
);
  import fhj_pkg::*;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_H0   = 4'd2;
  localparam logic [3:0] ST_H1   = 4'd3;
  localparam logic [3:0] ST_H2   = 4'd4;
  localparam logic [3:0] ST_H3   = 4'd5;
  localparam logic [3:0] ST_H4   = 4'd6;
  localparam logic [3:0] ST_H5   = 4'd7;
  localparam logic [3:0] ST_H6   = 4'd8;
  localparam logic [3:0] ST_CHK  = 4'd9;
  localparam logic [3:0] ST_WR   = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  localparam logic REQ_BUILD = 1'b0;

  logic [3:0]        state;
  logic [31:0]       wanted_app_id;
  logic [CNT_W-1:0]  entry_count;
  logic [IDX_W-1:0]  clr_addr;
  logic              req_probe;
  logic [KEY_W-1:0]  key;
  logic [PAY_W-1:0]  pay;
  logic [31:0]       trip;
  logic [63:0]       hreg;
  logic [63:0]       pa;
  logic [31:0]       pb;
  logic [31:0]       pc;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  walk;
  logic              is_new;
  logic              ovf;

  // memories
  logic [KEY_W:0]    key_mem [ENTRIES];
  logic [PAY_W-1:0]  pay_mem [ENTRIES];
  logic [KEY_W:0]    key_rd;
  logic [PAY_W-1:0]  pay_rd;
  logic [IDX_W-1:0]  key_addr;
  logic              key_we;
  logic [KEY_W:0]    key_wd;

  logic              s_acc;
  logic [KEY_W-1:0]  key_in;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       h1;
  logic [63:0]       h2;
  logic [63:0]       hf;
  logic [IDX_W-1:0]  idx0;
  logic [IDX_W-1:0]  idx_nx;
  logic              slot_valid;
  logic              slot_hit;
  logic              out_free;
  logic              out_load;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign key_in   = key_norm(s_tdata[79:0]);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_OUT) && out_free;

  // one shared 32x32 multiplier, operands by hash step
  always_comb begin
    mul_a = {16'd0, key[79:64]};
    mul_b = HASH_C1[31:0];
    case (state)
      ST_H1:   mul_b = HASH_C1[63:32];
      ST_H3: begin
        mul_a = hreg[31:0];
        mul_b = HASH_C2[31:0];
      end
      ST_H4: begin
        mul_a = hreg[31:0];
        mul_b = HASH_C2[63:32];
      end
      ST_H5: begin
        mul_a = hreg[63:32];
        mul_b = HASH_C2[31:0];
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // hash finish steps
  assign h1     = key[63:0] ^ (pa + {pb, 32'd0});
  assign h2     = pa + {pb + pc, 32'd0};
  assign hf     = h2 ^ (h2 >> 32);
  assign idx0   = hf[IDX_W-1:0];
  assign idx_nx = idx + 1'b1;

  assign slot_valid = key_rd[KEY_W];
  assign slot_hit   = slot_valid && (key_rd[KEY_W-1:0] == key);

  // key memory address and write port
  always_comb begin
    key_addr = idx;
    key_we   = 1'b0;
    key_wd   = {1'b1, key};
    case (state)
      ST_CLR: begin
        key_addr = clr_addr;
        key_we   = 1'b1;
        key_wd   = '0;
      end
      ST_H6:  key_addr = idx0;
      ST_CHK: key_addr = idx_nx;
      ST_WR:  key_we   = is_new;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_addr] <= key_wd;
    key_rd <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_WR) pay_mem[idx] <= pay;
    pay_rd <= pay_mem[idx];
  end

  // filter register
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_app_id <= 32'd34;
    end else if (cfg_we) begin
      wanted_app_id <= cfg_wdata;
    end
  end

  // item capture and hash datapath
  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_probe <= (s_tuser != REQ_BUILD);
      key       <= key_in;
      pay       <= {s_tdata[263:256], s_tdata[255:192], s_tdata[191:176],
                    s_tdata[175:112]};
      trip      <= s_tdata[295:264];
    end
    case (state)
      ST_H0: pa   <= mul_p;
      ST_H1: pb   <= mul_p[31:0];
      ST_H2: hreg <= h1 ^ (h1 >> 29);
      ST_H3: pa   <= mul_p;
      ST_H4: pb   <= mul_p[31:0];
      ST_H5: pc   <= mul_p[31:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      clr_addr    <= '0;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(ENTRIES - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          // filtered builds leave no trace
          if (s_acc && !(s_tuser == REQ_BUILD && s_tdata[111:80] != wanted_app_id))
            state <= ST_H0;
        end
        ST_H0: state <= ST_H1;
        ST_H1: state <= ST_H2;
        ST_H2: state <= ST_H3;
        ST_H3: state <= ST_H4;
        ST_H4: state <= ST_H5;
        ST_H5: state <= ST_H6;
        ST_H6: begin
          idx   <= idx0;
          walk  <= '0;
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (!slot_valid) begin
            // empty slot: insert point for a build
            is_new <= 1'b1;
            ovf    <= 1'b1;
            if (req_probe) state <= ST_IDLE;
            else if (entry_count >= CNT_W'(ENTRIES)) state <= ST_OUT;
            else state <= ST_WR;
          end else if (slot_hit) begin
            is_new <= 1'b0;
            ovf    <= 1'b0;
            state  <= req_probe ? ST_OUT : ST_WR;
          end else if (walk == CNT_W'(ENTRIES - 1)) begin
            // every slot holds another key
            ovf   <= 1'b1;
            state <= req_probe ? ST_IDLE : ST_OUT;
          end else begin
            idx  <= idx_nx;
            walk <= walk + 1'b1;
          end
        end
        ST_WR: begin
          if (is_new) entry_count <= entry_count + 1'b1;
          state <= ST_IDLE;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= ovf;
      if (ovf) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {pay_rd[151:144], pay_rd[143:80], trip, pay_rd[79:64],
                    pay_rd[63:0]};
      end
    end
  end

  // checks
  `FHJ_ASSERT_NOW(a_clr_no_accept, state == ST_CLR, !s_tready, "accept during clearing pass")
  `FHJ_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= CNT_W'(ENTRIES), "entry count overflow")
  `FHJ_ASSERT_NOW(a_out_no_overwrite, out_load, !m_tvalid || m_tready, "result overwritten")
  `FHJ_ASSERT_NXT(a_wr_new_count, state == ST_WR && is_new,
                  entry_count == $past(entry_count) + 1'b1, "entry count not bumped")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks build and probe traffic of the filtered hash join against a local
// table model, with random stalls on both streams and filter register changes
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL = 16384;

  // last field in the lowest bits, matching the tdata layout
  typedef struct packed {
    logic        is_probe;
    logic [31:0] trips;
    logic [7:0]  reg_hi;
    logic [63:0] reg_lo;
    logic [15:0] cust_hi;
    logic [63:0] cust_lo;
    logic [31:0] app_id;
    logic [15:0] key_hi;
    logic [63:0] key_lo;
  } row_t;

  typedef struct packed {
    logic        full;
    logic [7:0]  reg_hi;
    logic [63:0] reg_lo;
    logic [31:0] trips;
    logic [15:0] cust_hi;
    logic [63:0] cust_lo;
  } join_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [fhj_pkg::IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [fhj_pkg::OUT_W-1:0] m_tdata;
  logic m_tuser;

  filtered_hash_join_top DUT (.*);

  // join table model
  logic        tbl_used [TBL];
  logic [79:0] tbl_key  [TBL];
  logic [151:0] tbl_pay [TBL];
  int unsigned tbl_fill;
  logic [31:0] app_filter;

  row_t  pending_rows[$];
  join_t expected_joins[$];
  int    errors, beats_out, beats_in;
  bit    calm;
  int    send_gap, recv_gap;
  bit    in_flight;

  // wanted key pool so probes hit
  logic [79:0] key_pool[$];

  initial forever #4 clk = ~clk;

  function automatic logic [79:0] norm_key(logic [79:0] raw);
    logic [79:0] res;
    bit alive;
    res = '0;
    alive = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (raw[8*i +: 8] == 8'd0) alive = 1'b0;
      if (alive) res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction

  function automatic int unsigned slot_hash(logic [79:0] k);
    logic [63:0] h;
    h = k[63:0] ^ ({48'd0, k[79:64]} * 64'h9E3779B97F4A7C15);
    h ^= h >> 29;
    h *= 64'hBF58476D1CE4E5B9;
    h ^= h >> 32;
    // table size is a power of two
    return {18'd0, h[13:0]};
  endfunction

  // apply one row to the table model, maybe queue a join result
  task automatic predict_join(row_t r);
    logic [79:0] k;
    int unsigned idx, n;
    bit found, empty;
    join_t j;
    k = norm_key({r.key_hi, r.key_lo});
    idx = slot_hash(k);
    found = 0;
    empty = 0;
    for (n = 0; n < TBL; n++) begin
      if (!tbl_used[idx]) begin
        empty = 1;
        break;
      end
      if (tbl_key[idx] == k) begin
        found = 1;
        break;
      end
      idx = (idx + 1) % TBL;
    end
    if (!r.is_probe) begin
      if (r.app_id != app_filter) return;
      if (!found) begin
        if (!empty || tbl_fill >= TBL) begin
          j = '0;
          j.full = 1'b1;
          expected_joins.push_back(j);
          return;
        end
        tbl_used[idx] = 1'b1;
        tbl_key[idx] = k;
        tbl_fill++;
      end
      tbl_pay[idx] = {r.reg_hi, r.reg_lo, r.cust_hi, r.cust_lo};
    end else if (found) begin
      j.full = 1'b0;
      {j.reg_hi, j.reg_lo, j.cust_hi, j.cust_lo} = tbl_pay[idx];
      j.trips = r.trips;
      expected_joins.push_back(j);
    end
  endtask

  task automatic report(string what, logic [127:0] got, logic [127:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_join(row_t'({s_tuser, s_tdata}));
        beats_in++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        if (s_tvalid && s_tready) s_tvalid <= 1'b0;
      end else if ((!s_tvalid || s_tready) && pending_rows.size() > 0 && !calm
                   && !(s_tvalid && !s_tready)) begin
        if (!in_flight && $urandom_range(0, 15) == 0 && pending_rows.size() > 60)
          send_gap <= $urandom_range(1, 19);
        {s_tuser, s_tdata} <= pending_rows.pop_front();
        s_tvalid <= 1'b1;
      end else if (s_tvalid && s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    join_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        beats_out++;
        if (expected_joins.size() == 0) begin
          report("unexpected beat", got[127:0], '0);
        end else begin
          want = expected_joins.pop_front();
          if (got.full != want.full)
            report("status", 128'(got.full), 128'(want.full));
          if (got.cust_lo != want.cust_lo)
            report("customer_low", 128'(got.cust_lo), 128'(want.cust_lo));
          if (got.cust_hi != want.cust_hi)
            report("customer_high", 128'(got.cust_hi), 128'(want.cust_hi));
          if (got.trips != want.trips)
            report("trip_score", 128'(got.trips), 128'(want.trips));
          if (got.reg_lo != want.reg_lo)
            report("region_low", 128'(got.reg_lo), 128'(want.reg_lo));
          if (got.reg_hi != want.reg_hi)
            report("region_high", 128'(got.reg_hi), 128'(want.reg_hi));
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!in_flight && $urandom_range(0, 20) == 0) begin
        recv_gap <= $urandom_range(1, 19);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [79:0] rand_key();
    logic [79:0] k;
    k = {16'($urandom), $urandom, $urandom};
    // often cut the string short
    if ($urandom_range(0, 3) == 0) k[8*$urandom_range(0, 9) +: 8] = 8'd0;
    return k;
  endfunction

  function automatic row_t make_row(bit probe, logic [79:0] k, logic [31:0] app);
    row_t r;
    r.is_probe = probe;
    {r.key_hi, r.key_lo} = k;
    r.app_id = app;
    r.cust_lo = {$urandom, $urandom};
    r.cust_hi = 16'($urandom);
    r.reg_lo = {$urandom, $urandom};
    r.reg_hi = 8'($urandom);
    r.trips = $urandom;
    return r;
  endfunction

  // wait for the queues to drain, then allow the walk to settle
  task automatic drain();
    wait (pending_rows.size() == 0 && !s_tvalid);
    wait (expected_joins.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_filter(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    app_filter = v;
  endtask

  // random phase: builds that mostly pass the filter and probes mostly on known keys
  task automatic random_phase(int count);
    logic [79:0] k;
    logic [31:0] app;
    bit probe;
    for (int i = 0; i < count; i++) begin
      probe = 1'($urandom_range(0, 1));
      if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else
        k = rand_key();
      app = ($urandom_range(0, 5) == 0) ? $urandom : app_filter;
      if (!probe) key_pool.push_back(k);
      pending_rows.push_back(make_row(probe, k, app));
    end
  endtask

  initial begin
    row_t r;
    app_filter = 32'd34;
    tbl_fill = 0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    calm = 0;
    send_gap = 0;
    recv_gap = 0;
    in_flight = 0;
    for (int i = 0; i < TBL; i++) tbl_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme keys, filters, overwrite, miss, strings
    pending_rows.push_back(make_row(0, {80{1'b1}}, 32'd34));
    pending_rows.push_back(make_row(1, {80{1'b1}}, 32'd0));
    pending_rows.push_back(make_row(0, 80'h0, 32'd34));
    pending_rows.push_back(make_row(1, 80'h0, 32'd7));
    pending_rows.push_back(make_row(0, 80'h41, 32'd34));
    pending_rows.push_back(make_row(0, 80'h41, 32'd34));
    pending_rows.push_back(make_row(1, 80'hFFFF_0000_0041, 32'd0));
    pending_rows.push_back(make_row(0, 80'h4242, 32'd35));
    pending_rows.push_back(make_row(1, 80'h4242, 32'd0));
    pending_rows.push_back(make_row(1, 80'h1234_5678, 32'd0));
    pending_rows.push_back(make_row(0, {8'h00, {9{8'h61}}}, 32'd34));
    pending_rows.push_back(make_row(1, {8'h7F, {9{8'h61}}}, 32'd0));
    r = make_row(1, {80{1'b1}}, 32'd0);
    r.trips = 32'h8000_0000;
    pending_rows.push_back(r);
    r.trips = 32'h7FFF_FFFF;
    r.cust_lo = '0;
    pending_rows.push_back(r);
    drain();

    // filter extremes
    set_filter(32'h8000_0000);
    random_phase(350);
    in_flight = 1;
    drain();
    in_flight = 0;
    set_filter(32'h7FFF_FFFF);
    random_phase(350);
    drain();
    set_filter($urandom);
    random_phase(350);
    drain();
    set_filter(32'd34);
    random_phase(300);
    wait (pending_rows.size() < 150);
    calm = 0;
    random_phase(200);
    // quiet tail: no stalls
    wait (pending_rows.size() < 100);
    in_flight = 1;
    drain();

    $display("rows sent %0d, join beats %0d, table fill %0d", beats_in, beats_out,
             tbl_fill);
    $display("covered filter extremes, overwrites, misses and short string keys");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
